>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/ssa_pkg.sv
package ssa_pkg;

   localparam int MAX_SLOTS_DEF = 4096;
   localparam int ID_W          = 64;
   localparam int GEN_W         = 8 * 6;
   localparam int IDX_W         = ID_W - GEN_W;
   localparam int OUT_IDX_W     = 13;
   localparam int OP_W          = 2;
   localparam int STATUS_W      = 2;
   localparam int CFG_W         = 13;
   localparam int CMP_W         = 17;
   localparam int CSR_AW        = 3;
   localparam int CSR_DW        = 32;

   localparam logic [CFG_W-1:0] MAX_SESSIONS_RST = 13'd4096;
   localparam logic [0:0]       REG_MAX_SESSIONS = 1'b0;

   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY       = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_IN_USE  = 2'd3;

   typedef struct packed {
      logic clear;
      logic capture;
      logic read;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic out_free;
   } stat_type;

endpackage

>>> src/ssa_if.sv
interface ssa_req_if;
   logic                      valid;
   logic                      ready;
   logic [ssa_pkg::OP_W-1:0]  opcode;
   logic [ssa_pkg::ID_W-1:0]  conn_id;

   modport source (output valid, opcode, conn_id, input ready);
   modport sink (input valid, opcode, conn_id, output ready);
endinterface

interface ssa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ssa_pkg::STATUS_W-1:0]  status;
   logic [ssa_pkg::ID_W-1:0]      granted_id;
   logic [ssa_pkg::OUT_IDX_W-1:0] slot_index;
   logic                          slot_in_use;

   modport source (output valid, status, granted_id, slot_index, slot_in_use, input ready);
   modport sink (input valid, status, granted_id, slot_index, slot_in_use, output ready);
endinterface

>>> src/ssa_csr.sv
module ssa_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ssa_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [ssa_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [ssa_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready,
   output logic [ssa_pkg::CFG_W-1:0]    max_sessions
);

   logic                       sel;
   logic                       wr_en;
   logic [ssa_pkg::CFG_W-1:0]  max_sessions_ff;
   logic [ssa_pkg::CFG_W-1:0]  max_sessions_in;

   always_comb begin
      sel             = (csr_paddr[ssa_pkg::CSR_AW-1:2] == ssa_pkg::REG_MAX_SESSIONS);
      wr_en           = csr_psel && csr_penable && csr_pwrite;
      max_sessions_in = max_sessions_ff;
      if (wr_en && sel) begin
         max_sessions_in = csr_pwdata[ssa_pkg::CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_sessions_ff <= ssa_pkg::MAX_SESSIONS_RST;
      end else begin
         max_sessions_ff <= max_sessions_in;
      end
   end

   assign csr_prdata   = sel ? ssa_pkg::CSR_DW'(max_sessions_ff) : '0;
   assign csr_pready   = 1'b1;
   assign max_sessions = max_sessions_ff;

endmodule

>>> src/ssa_ctrl.sv
module ssa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ssa_pkg::stat_type stat,
   output ssa_pkg::cmd_type  cmd
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_READ  = 2'd2;
   localparam logic [1:0] S_EXEC  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/ssa_datapath.sv
module ssa_datapath #(
   parameter int MAX_SLOTS = ssa_pkg::MAX_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ssa_pkg::cmd_type                cmd,
   output ssa_pkg::stat_type               stat,
   input  logic [ssa_pkg::CFG_W-1:0]       max_sessions,
   input  logic [ssa_pkg::OP_W-1:0]        req_opcode,
   input  logic [ssa_pkg::ID_W-1:0]        req_conn_id,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ssa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ssa_pkg::ID_W-1:0]        rsp_granted_id,
   output logic [ssa_pkg::OUT_IDX_W-1:0]   rsp_slot_index,
   output logic                            rsp_slot_in_use
);

   localparam int SLOT_W   = $clog2(MAX_SLOTS + 1);
   localparam int STACK_AW = $clog2(MAX_SLOTS);
   localparam int FRESH_W  = $clog2(MAX_SLOTS + 2);
   localparam int CMP_W    = ssa_pkg::CMP_W;

   logic [SLOT_W-1:0] stack_mem [MAX_SLOTS];
   logic              busy_mem  [MAX_SLOTS + 1];

   logic [ssa_pkg::OP_W-1:0]   op_ff;
   logic [ssa_pkg::IDX_W-1:0]  idx_ff;
   logic [SLOT_W-1:0]          clr_ff;
   logic [SLOT_W-1:0]          clr_in;
   logic [SLOT_W-1:0]          depth_ff;
   logic [SLOT_W-1:0]          depth_in;
   logic [FRESH_W-1:0]         fresh_ff;
   logic [FRESH_W-1:0]         fresh_in;
   logic [ssa_pkg::GEN_W-1:0]  gen_ff;
   logic [ssa_pkg::GEN_W-1:0]  gen_in;
   logic [SLOT_W-1:0]          stack_rd_ff;
   logic                       busy_rd_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [ssa_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [ssa_pkg::ID_W-1:0]      rsp_gid_ff;
   logic [ssa_pkg::OUT_IDX_W-1:0] rsp_slot_ff;
   logic                          rsp_busy_ff;

   logic [CMP_W-1:0]              lim;
   logic                          idx_ok;
   logic                          has_stack;
   logic                          has_fresh;
   logic [SLOT_W-1:0]             depth_m1;
   logic [SLOT_W-1:0]             alloc_slot;
   logic [SLOT_W-1:0]             busy_rd_addr;
   logic [SLOT_W-1:0]             busy_wa;
   logic                          busy_wd;
   logic                          busy_we;
   logic                          stack_we;
   logic                          depth_inc;
   logic                          depth_dec;
   logic                          fresh_inc;
   logic                          gen_inc;
   logic [ssa_pkg::STATUS_W-1:0]  res_status;
   logic [ssa_pkg::ID_W-1:0]      res_gid;
   logic [ssa_pkg::OUT_IDX_W-1:0] res_slot;
   logic                          res_busy;

   always_comb begin
      lim = (CMP_W'(max_sessions) > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS)
                                                       : CMP_W'(max_sessions);
      idx_ok       = (idx_ff != '0) && (CMP_W'(idx_ff) <= lim);
      has_stack    = (depth_ff != '0);
      has_fresh    = (CMP_W'(fresh_ff) <= lim);
      depth_m1     = depth_ff - SLOT_W'(1);
      alloc_slot   = has_stack ? stack_rd_ff : fresh_ff[SLOT_W-1:0];
      busy_rd_addr = idx_ok ? idx_ff[SLOT_W-1:0] : '0;
   end

   always_comb begin
      res_status = ssa_pkg::ST_OK;
      res_gid    = '0;
      res_slot   = '0;
      res_busy   = 1'b0;
      busy_we    = 1'b0;
      busy_wa    = '0;
      busy_wd    = 1'b0;
      stack_we   = 1'b0;
      depth_inc  = 1'b0;
      depth_dec  = 1'b0;
      fresh_inc  = 1'b0;
      gen_inc    = 1'b0;
      case (op_ff)
         ssa_pkg::OP_ALLOC: begin
            if (has_stack || has_fresh) begin
               res_gid   = {ssa_pkg::IDX_W'(alloc_slot), gen_ff};
               res_slot  = ssa_pkg::OUT_IDX_W'(alloc_slot);
               res_busy  = 1'b1;
               busy_we   = 1'b1;
               busy_wa   = alloc_slot;
               busy_wd   = 1'b1;
               depth_dec = has_stack;
               fresh_inc = !has_stack;
               gen_inc   = 1'b1;
            end else begin
               res_status = ssa_pkg::ST_EMPTY;
            end
         end
         ssa_pkg::OP_RELEASE: begin
            res_slot = ssa_pkg::OUT_IDX_W'(idx_ff);
            if (!idx_ok) begin
               res_status = ssa_pkg::ST_BAD_INDEX;
            end else if (!busy_rd_ff) begin
               res_status = ssa_pkg::ST_NOT_IN_USE;
            end else begin
               busy_we = 1'b1;
               busy_wa = idx_ff[SLOT_W-1:0];
               busy_wd = 1'b0;
               if (depth_ff < SLOT_W'(MAX_SLOTS)) begin
                  stack_we  = 1'b1;
                  depth_inc = 1'b1;
               end
            end
         end
         ssa_pkg::OP_LOOKUP: begin
            res_slot = ssa_pkg::OUT_IDX_W'(idx_ff);
            if (!idx_ok) begin
               res_status = ssa_pkg::ST_BAD_INDEX;
            end else begin
               res_busy = busy_rd_ff;
            end
         end
         default: begin
            res_status = ssa_pkg::ST_OK;
         end
      endcase
   end

   always_comb begin
      clr_in   = clr_ff;
      depth_in = depth_ff;
      fresh_in = fresh_ff;
      gen_in   = gen_ff;
      if (cmd.clear && !stat.clear_done) begin
         clr_in = clr_ff + SLOT_W'(1);
      end
      if (cmd.commit) begin
         if (depth_inc) begin
            depth_in = depth_ff + SLOT_W'(1);
         end else if (depth_dec) begin
            depth_in = depth_m1;
         end
         if (fresh_inc) begin
            fresh_in = fresh_ff + FRESH_W'(1);
         end
         if (gen_inc) begin
            gen_in = gen_ff + ssa_pkg::GEN_W'(1);
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         depth_ff     <= '0;
         fresh_ff     <= FRESH_W'(1);
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         depth_ff     <= depth_in;
         fresh_ff     <= fresh_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_opcode;
         idx_ff <= req_conn_id[ssa_pkg::ID_W-1:ssa_pkg::GEN_W];
      end
      if (cmd.commit) begin
         rsp_status_ff <= res_status;
         rsp_gid_ff    <= res_gid;
         rsp_slot_ff   <= res_slot;
         rsp_busy_ff   <= res_busy;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         stack_rd_ff <= stack_mem[depth_m1[STACK_AW-1:0]];
      end
      if (cmd.commit && stack_we) begin
         stack_mem[depth_ff[STACK_AW-1:0]] <= idx_ff[SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         busy_rd_ff <= busy_mem[busy_rd_addr];
      end
      if (cmd.clear) begin
         busy_mem[clr_ff] <= 1'b0;
      end else if (cmd.commit && busy_we) begin
         busy_mem[busy_wa] <= busy_wd;
      end
   end

   assign stat.clear_done = (clr_ff == SLOT_W'(MAX_SLOTS));
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_granted_id  = rsp_gid_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_slot_in_use = rsp_busy_ff;

endmodule

>>> src/session_slot_id_allocator.sv
// Session slot allocator. Each request allocates, releases or looks up a slot numbered 1 to
// the smaller of max_sessions and MAX_SLOTS and produces exactly one response; allocation
// hands out the most recently released slot first and otherwise the lowest slot never used,
// tagged with a 48-bit generation count in the low bits of the 64-bit ID and the slot index
// in the top 16 bits. A request goes from acceptance to the response register by accept, a
// read of the released-slot stack and the in-use memory, then the update, which waits while
// an untaken response is held; a new request is accepted only after that update. After
// reset the in-use memory is cleared one entry a cycle, during which no request is accepted;
// register writes are taken at any time while idle.
module session_slot_id_allocator #(
   parameter int MAX_SLOTS = ssa_pkg::MAX_SLOTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   ssa_req_if.sink                      req_ch,
   ssa_rsp_if.source                    rsp_ch,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ssa_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [ssa_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [ssa_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);

   ssa_pkg::cmd_type           cmd;
   ssa_pkg::stat_type          stat;
   logic [ssa_pkg::CFG_W-1:0]  max_sessions;

   ssa_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .max_sessions (max_sessions)
   );

   ssa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ssa_datapath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .max_sessions    (max_sessions),
      .req_opcode      (req_ch.opcode),
      .req_conn_id     (req_ch.conn_id),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_status      (rsp_ch.status),
      .rsp_granted_id  (rsp_ch.granted_id),
      .rsp_slot_index  (rsp_ch.slot_index),
      .rsp_slot_in_use (rsp_ch.slot_in_use)
   );

endmodule

>>> src/ssa_checker.sv
`include "assert_macros.svh"

module ssa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [ssa_pkg::STATUS_W-1:0]    rsp_status,
   input logic [ssa_pkg::ID_W-1:0]        rsp_granted_id,
   input logic [ssa_pkg::OUT_IDX_W-1:0]   rsp_slot_index,
   input logic                            rsp_slot_in_use
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_granted_id) && $stable(rsp_status))
   `ASSERT_IMPL(a_grant_index, clock, reset, rsp_valid && (rsp_granted_id != 64'd0), (rsp_status == ssa_pkg::ST_OK) && rsp_slot_in_use && (rsp_granted_id[60:48] == rsp_slot_index))
   `ASSERT_IMPL(a_fail_clean, clock, reset, rsp_valid && (rsp_status != ssa_pkg::ST_OK), !rsp_slot_in_use && (rsp_granted_id == 64'd0))
   `ASSERT_IMPL(a_reset_quiet, clock, 1'b0, $past(reset), !rsp_valid && !req_ready)

endmodule

bind session_slot_id_allocator ssa_checker u_ssa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_granted_id  (rsp_ch.granted_id),
   .rsp_slot_index  (rsp_ch.slot_index),
   .rsp_slot_in_use (rsp_ch.slot_in_use)
);
